>>> design/deq_pkg.sv
`default_nettype none

package deq_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 9;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;
  localparam logic [OP_W-1:0] OP_WRITE      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic rotate;
    logic up;
  } ring_ctrl_t;

endpackage

`default_nettype wire

>>> design/double_ended_queue.sv
// Double-ended queue held in a closed ring of CAPACITY cells. A push, pop or write request
// is taken while busy is low; its result is strobed in the next cycle with busy staying low,
// so these requests can be issued every cycle. A read request rotates the ring one cell per
// cycle toward the requested element along the shorter way round, by at most CAPACITY / 2
// cells; busy is high while it rotates, and the result is strobed after it reaches cell 0.
// Results cannot be held off, so the receiver must take each strobed result in its cycle.
// Failed requests are also strobed in the next cycle, and they change nothing.
`default_nettype none

module double_ended_queue #(
  parameter int CAPACITY   = deq_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = deq_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [deq_pkg::OP_W-1:0]       in_op,
  input  wire logic [deq_pkg::VALUE_W-1:0]    in_value,
  input  wire logic [deq_pkg::POS_W-1:0]      in_position,
  output logic                                out_strobe,
  output logic      [deq_pkg::STATUS_W-1:0]   out_status,
  output logic      [deq_pkg::VALUE_W-1:0]    out_read_value,
  output logic      [deq_pkg::FILL_W-1:0]     out_fill_level
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int SW    = AW + 1;
  localparam int CMPW  = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;
  localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
  localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);
  localparam logic [AW-1:0] HALF_A = AW'(CAPACITY / 2);
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_SEEK
  } state_t;

  state_t                          state_r, state_nxt;
  logic [AW-1:0]                   front_r, front_nxt;
  logic [AW-1:0]                   rot_r, rot_nxt;
  logic [AW-1:0]                   target_r, target_nxt;
  logic                            dir_up_r, dir_up_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic                            out_strobe_r, out_strobe_nxt;
  logic [deq_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic [deq_pkg::VALUE_W-1:0]     out_read_value_r, out_read_value_nxt;
  logic [deq_pkg::FILL_W-1:0]      out_fill_level_r, out_fill_level_nxt;

  logic                            accept;
  logic                            is_full;
  logic                            is_empty;
  logic                            in_range;
  logic [SW-1:0]                   front_plus_pos;
  logic [SW-1:0]                   front_plus_cnt;
  logic [AW-1:0]                   slot_pos;
  logic [AW-1:0]                   slot_back;
  logic [AW-1:0]                   front_dec;
  logic [AW-1:0]                   front_inc;
  logic [AW-1:0]                   rot_inc;
  logic [AW-1:0]                   rot_dec;
  logic [AW-1:0]                   sel_slot;
  logic [SW-1:0]                   cell_diff;
  logic [AW-1:0]                   cell_idx;
  logic                            wr_any;
  logic [63:0]                     val_wide;
  logic [63:0]                     rd_wide;
  logic [ELEM_WIDTH-1:0]           wr_data;
  logic [ELEM_WIDTH-1:0]           cell_q [CAPACITY];
  deq_pkg::ring_ctrl_t             ring_ctrl;

  assign accept   = start && !busy;
  assign busy     = (state_r == S_SEEK);
  assign is_full  = (count_r == CAP_C);
  assign is_empty = (count_r == '0);
  assign in_range = CMPW'(in_position) < CMPW'(count_r);

  assign val_wide = 64'(in_value);
  assign wr_data  = val_wide[ELEM_WIDTH-1:0];
  assign rd_wide  = 64'(cell_q[0]);

  assign front_plus_pos = SW'(front_r) + SW'(in_position);
  assign front_plus_cnt = SW'(front_r) + SW'(count_r);
  assign slot_pos  = (front_plus_pos >= CAP_S) ? AW'(front_plus_pos - CAP_S)
                                               : AW'(front_plus_pos);
  assign slot_back = (front_plus_cnt >= CAP_S) ? AW'(front_plus_cnt - CAP_S)
                                               : AW'(front_plus_cnt);
  assign front_dec = (front_r == '0) ? LAST_A : front_r - AW'(1);
  assign front_inc = (front_r == LAST_A) ? '0 : front_r + AW'(1);
  assign rot_inc   = (rot_r == LAST_A) ? '0 : rot_r + AW'(1);
  assign rot_dec   = (rot_r == '0) ? LAST_A : rot_r - AW'(1);

  always_comb begin
    case (in_op)
      deq_pkg::OP_PUSH_BACK:  sel_slot = slot_back;
      deq_pkg::OP_PUSH_FRONT: sel_slot = front_dec;
      default:                sel_slot = slot_pos;
    endcase
  end

  // The cell that holds a ring slot, which is also the upward rotation distance to it.
  assign cell_diff = SW'(sel_slot) + CAP_S - SW'(rot_r);
  assign cell_idx  = (cell_diff >= CAP_S) ? AW'(cell_diff - CAP_S) : AW'(cell_diff);

  always_comb begin
    state_nxt          = state_r;
    front_nxt          = front_r;
    rot_nxt            = rot_r;
    target_nxt         = target_r;
    dir_up_nxt         = dir_up_r;
    count_nxt          = count_r;
    out_strobe_nxt     = 1'b0;
    out_status_nxt     = out_status_r;
    out_read_value_nxt = out_read_value_r;
    out_fill_level_nxt = out_fill_level_r;
    wr_any             = 1'b0;
    ring_ctrl.rotate   = 1'b0;
    ring_ctrl.up       = dir_up_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_strobe_nxt     = 1'b1;
          out_status_nxt     = deq_pkg::ST_OK;
          out_read_value_nxt = '0;
          case (in_op)
            deq_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                out_status_nxt = deq_pkg::ST_FULL;
              end else begin
                wr_any    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            deq_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                out_status_nxt = deq_pkg::ST_FULL;
              end else begin
                wr_any    = 1'b1;
                front_nxt = front_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            deq_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                out_status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            deq_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                out_status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                front_nxt = front_inc;
                count_nxt = count_r - CW'(1);
              end
            end
            deq_pkg::OP_READ: begin
              if (!in_range) begin
                out_status_nxt = deq_pkg::ST_RANGE;
              end else begin
                out_strobe_nxt = 1'b0;
                target_nxt     = slot_pos;
                dir_up_nxt     = (cell_idx <= HALF_A);
                state_nxt      = S_SEEK;
              end
            end
            deq_pkg::OP_WRITE: begin
              if (!in_range) begin
                out_status_nxt = deq_pkg::ST_RANGE;
              end else begin
                wr_any = 1'b1;
              end
            end
            default: begin
            end
          endcase
          out_fill_level_nxt = deq_pkg::FILL_W'(count_nxt);
        end
      end
      S_SEEK: begin
        if (rot_r == target_r) begin
          out_strobe_nxt     = 1'b1;
          out_status_nxt     = deq_pkg::ST_OK;
          out_read_value_nxt = rd_wide[deq_pkg::VALUE_W-1:0];
          out_fill_level_nxt = deq_pkg::FILL_W'(count_r);
          state_nxt          = S_IDLE;
        end else begin
          ring_ctrl.rotate = 1'b1;
          rot_nxt          = dir_up_r ? rot_inc : rot_dec;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      front_r      <= '0;
      rot_r        <= '0;
      target_r     <= '0;
      dir_up_r     <= 1'b0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      front_r      <= front_nxt;
      rot_r        <= rot_nxt;
      target_r     <= target_nxt;
      dir_up_r     <= dir_up_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    out_status_r     <= out_status_nxt;
    out_read_value_r <= out_read_value_nxt;
    out_fill_level_r <= out_fill_level_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_fill_level = out_fill_level_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    deq_cell #(
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ring_ctrl),
      .wr_en     (wr_any && (cell_idx == AW'(i))),
      .wr_data   (wr_data),
      .up_data   (cell_q[(i + 1) % CAPACITY]),
      .down_data (cell_q[(i + CAPACITY - 1) % CAPACITY]),
      .q         (cell_q[i])
    );
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("Result strobed while a read is still rotating the ring.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op != deq_pkg::OP_READ) |=> out_strobe)
    else $error("A non-read request did not produce a result in the next cycle.");

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("Element count exceeds the capacity.");

  assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> (rot_r == $past(rot_r)))
    else $error("Ring rotated while no read was in progress.");

  assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> ($stable(front_r) && $stable(count_r)))
    else $error("Front or count changed during a read.");

endmodule

`default_nettype wire

>>> design/deq_cell.sv
`default_nettype none

module deq_cell #(
  parameter int ELEM_WIDTH = deq_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire deq_pkg::ring_ctrl_t    ctrl,
  input  wire logic                   wr_en,
  input  wire logic [ELEM_WIDTH-1:0]  wr_data,
  input  wire logic [ELEM_WIDTH-1:0]  up_data,
  input  wire logic [ELEM_WIDTH-1:0]  down_data,
  output logic      [ELEM_WIDTH-1:0]  q
);

  logic [ELEM_WIDTH-1:0] data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      data_r <= wr_data;
    end else if (ctrl.rotate) begin
      data_r <= ctrl.up ? up_data : down_data;
    end
  end

  assign q = data_r;

endmodule

`default_nettype wire

>>> tb/double_ended_queue_test.sv
`timescale 1ns / 1ps

module double_ended_queue_test;

  localparam int DEPTH = deq_pkg::CAPACITY_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [deq_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [deq_pkg::STATUS_W-1:0] status;
    logic [deq_pkg::VALUE_W-1:0]  read_value;
    logic [deq_pkg::FILL_W-1:0]   fill_level;
  } deq_result_t;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic [deq_pkg::OP_W-1:0]     in_op = '0;
  logic [deq_pkg::VALUE_W-1:0]  in_value = '0;
  logic [deq_pkg::POS_W-1:0]    in_position = '0;
  wire                          busy;
  wire                          out_strobe;
  wire [deq_pkg::STATUS_W-1:0]  out_status;
  wire [deq_pkg::VALUE_W-1:0]   out_read_value;
  wire [deq_pkg::FILL_W-1:0]    out_fill_level;

  logic [deq_pkg::VALUE_W-1:0] shadow_ring [DEPTH];
  int shadow_front = 0;
  int shadow_count = 0;
  deq_result_t expected_results [$];
  int error_count = 0;
  int idle_cycles = 0;
  int gap_max = 7;

  double_ended_queue dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_fill_level (out_fill_level)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic deq_result_t apply_request(input logic [deq_pkg::OP_W-1:0] op,
                                                input logic [deq_pkg::VALUE_W-1:0] value,
                                                input logic [deq_pkg::POS_W-1:0] position);
    deq_result_t r;
    r.status = deq_pkg::ST_OK;
    r.read_value = '0;
    case (op)
      deq_pkg::OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          shadow_ring[(shadow_front + shadow_count) % DEPTH] = value;
          shadow_count++;
        end
      end
      deq_pkg::OP_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_front] = value;
          shadow_count++;
        end
      end
      deq_pkg::OP_POP_BACK: begin
        if (shadow_count == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          shadow_count--;
        end
      end
      deq_pkg::OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
        end
      end
      deq_pkg::OP_READ: begin
        if (int'(position) >= shadow_count) begin
          r.status = deq_pkg::ST_RANGE;
        end else begin
          r.read_value = shadow_ring[(shadow_front + int'(position)) % DEPTH];
        end
      end
      deq_pkg::OP_WRITE: begin
        if (int'(position) >= shadow_count) begin
          r.status = deq_pkg::ST_RANGE;
        end else begin
          shadow_ring[(shadow_front + int'(position)) % DEPTH] = value;
        end
      end
      default: begin
      end
    endcase
    r.fill_level = deq_pkg::FILL_W'(shadow_count);
    return r;
  endfunction

  // Start stays high across back-to-back requests and is lowered only for a gap.
  task automatic send_request(input logic [deq_pkg::OP_W-1:0] op,
                              input logic [deq_pkg::VALUE_W-1:0] value,
                              input logic [deq_pkg::POS_W-1:0] position);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_value <= value;
    in_position <= position;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.insert(expected_results.size(), apply_request(op, value, position));
  endtask

  function automatic logic [deq_pkg::POS_W-1:0] pick_position();
    if (shadow_count > 0 && $urandom_range(9, 0) != 0) begin
      return deq_pkg::POS_W'($urandom_range(shadow_count - 1, 0));
    end
    return deq_pkg::POS_W'($urandom_range((1 << deq_pkg::POS_W) - 1, 0));
  endfunction

  task automatic test_empty_queue();
    send_request(deq_pkg::OP_POP_BACK, $urandom(), '0);
    send_request(deq_pkg::OP_POP_FRONT, $urandom(), '1);
    send_request(deq_pkg::OP_READ, $urandom(), '0);
    send_request(deq_pkg::OP_WRITE, '1, '0);
    send_request(deq_pkg::OP_READ, $urandom(), '1);
  endtask

  task automatic test_value_extremes();
    send_request(deq_pkg::OP_PUSH_BACK, '0, '1);
    send_request(deq_pkg::OP_PUSH_FRONT, '1, '0);
    send_request(deq_pkg::OP_PUSH_BACK, 32'hA5A5_A5A5, '0);
    send_request(deq_pkg::OP_READ, $urandom(), 8'd0);
    send_request(deq_pkg::OP_READ, $urandom(), 8'd1);
    send_request(deq_pkg::OP_READ, $urandom(), 8'd2);
    send_request(deq_pkg::OP_READ, $urandom(), 8'd3);
    send_request(deq_pkg::OP_WRITE, 32'h5A5A_5A5A, 8'd2);
    send_request(deq_pkg::OP_READ, $urandom(), 8'd2);
    send_request(deq_pkg::OP_WRITE, '1, 8'd3);
  endtask

  task automatic test_unused_codes();
    send_request(OP_SPARE_6, $urandom(), deq_pkg::POS_W'($urandom()));
    send_request(OP_SPARE_7, $urandom(), deq_pkg::POS_W'($urandom()));
  endtask

  task automatic test_pops();
    send_request(deq_pkg::OP_POP_FRONT, $urandom(), '0);
    send_request(deq_pkg::OP_POP_BACK, $urandom(), '0);
    send_request(deq_pkg::OP_READ, $urandom(), '0);
    send_request(deq_pkg::OP_POP_BACK, $urandom(), '0);
    send_request(deq_pkg::OP_POP_BACK, $urandom(), '0);
  endtask

  task automatic test_full_queue();
    gap_max = 0;
    while (shadow_count < DEPTH) begin
      send_request($urandom_range(1, 0) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK,
                   $urandom(), deq_pkg::POS_W'($urandom()));
    end
    send_request(deq_pkg::OP_PUSH_BACK, $urandom(), '0);
    send_request(deq_pkg::OP_PUSH_FRONT, $urandom(), '0);
    gap_max = 7;
    send_request(deq_pkg::OP_READ, $urandom(), '0);
    send_request(deq_pkg::OP_READ, $urandom(), '1);
    send_request(deq_pkg::OP_WRITE, $urandom(), '1);
    send_request(deq_pkg::OP_READ, $urandom(), '1);
    repeat (12) begin
      send_request($urandom_range(1, 0) ? deq_pkg::OP_READ : deq_pkg::OP_WRITE, $urandom(),
                   pick_position());
    end
    while (shadow_count > 0) begin
      gap_max = ($urandom_range(3, 0) == 0) ? 7 : 0;
      send_request($urandom_range(1, 0) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK,
                   $urandom(), deq_pkg::POS_W'($urandom()));
    end
    send_request(deq_pkg::OP_POP_FRONT, $urandom(), '0);
    send_request(deq_pkg::OP_POP_BACK, $urandom(), '0);
  endtask

  task automatic test_random_traffic();
    int push_w;
    int pop_w;
    int pick;
    logic [deq_pkg::OP_W-1:0] op;
    repeat (20) begin
      gap_max = $urandom_range(1, 0) ? 7 : 0;
      case ($urandom_range(2, 0))
        0: begin
          push_w = 60;
          pop_w = 15;
        end
        1: begin
          push_w = 15;
          pop_w = 60;
        end
        default: begin
          push_w = 35;
          pop_w = 35;
        end
      endcase
      repeat (40) begin
        pick = $urandom_range(99, 0);
        if (pick < push_w) begin
          op = $urandom_range(1, 0) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
        end else if (pick < push_w + pop_w) begin
          op = $urandom_range(1, 0) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
        end else if (pick < 97) begin
          op = $urandom_range(1, 0) ? deq_pkg::OP_READ : deq_pkg::OP_WRITE;
        end else begin
          op = $urandom_range(1, 0) ? OP_SPARE_6 : OP_SPARE_7;
        end
        send_request(op, $urandom(), pick_position());
      end
    end
  endtask

  always @(posedge clk) begin
    deq_result_t want;
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("double_ended_queue: mismatch");
        $finish;
      end else if (out_strobe) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: status %0d, fill_level %0d",
                 out_status, out_fill_level);
          error_count++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            error_count++;
          end
          if (out_read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, out_read_value);
            error_count++;
          end
          if (out_fill_level !== want.fill_level) begin
            $error("fill_level: expected %0d, got %0d", want.fill_level, out_fill_level);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_value_extremes();
    test_unused_codes();
    test_pops();
    test_full_queue();
    test_random_traffic();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("double_ended_queue: match");
    end else begin
      $display("double_ended_queue: mismatch");
    end
    $finish;
  end

endmodule
